FILE: hw/rtl/qrv_pkg.sv
// Shared types and fixed widths for the quaternion vector rotation pipeline.
package qrv_pkg;

  // Quaternion part: 16-bit signed two's complement.
  localparam int QUAT_W  = 16;
  // Fraction bits of the normalized conjugate.
  localparam int C_FRAC  = 30;
  // Signed width of one conjugate part (magnitude never exceeds 2^30).
  localparam int C_W     = 32;
  // Square root of n2 * 2^30: n2 <= 2^32, so the root is at most 2^31.
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 64;
  localparam int REM_W   = ROOT_W + 2;
  // Quotient bits of the conjugate divide (quotient <= 2^30).
  localparam int QUOT_W  = 31;
  // Width of the dividend |q| * 2^45 + floor(m/2).
  localparam int NUM_W   = QUAT_W + 45;
  // Products q_i * c_j and rotation matrix entries.
  localparam int QC_W    = QUAT_W + C_W;
  localparam int M_W     = QC_W + 2;
  // Matrix entries are split into a signed high part and an unsigned low part.
  localparam int SPLIT   = 25;

  // Pipeline stage counts of the units.
  localparam int SQ_LAT  = ROOT_W + 1;
  localparam int DIV_LAT = QUOT_W + 2;
  localparam int ROT_LAT = 6;

  typedef logic signed [QUAT_W-1:0] qpart_t;
  typedef qpart_t [3:0]             quat_t;
  typedef logic signed [C_W-1:0]    cpart_t;
  typedef cpart_t [3:0]             conj_t;

endpackage

FILE: hw/rtl/quaternion_rotate_vector_unit.sv
// Top level of the quaternion vector rotation pipeline.
//
// Usage: drive quat_w..quat_z (signed, QUAT_FRAC_BITS fraction bits) and
// vec_x..vec_z (signed VEC_WIDTH bits) with start high; the beat is taken at
// a rising edge where start is high and busy is low. busy is low whenever rst
// is low, so a new beat can enter on every cycle.
// rot_x, rot_y, rot_z and clipped are valid for the single cycle in which
// done is high, after the beat has passed through every stage below.
// Stages: 1 input register, 33 square-root stages (an entry register and 32
// root-bit steps), 33 divider stages (an entry register, 31 quotient-bit steps
// on four lanes side by side and a sign stage) and 6 product/round/saturate
// stages. Throughput is one beat per cycle.
// clipped is high when any component exceeded the signed VEC_WIDTH range.
// A zero quaternion yields a zero vector with clipped low.
// Synchronous reset drops every beat in flight; no result comes out of a
// beat that was inside the pipeline at reset. The receiver cannot stall:
// each result is shown for exactly one cycle.
module quaternion_rotate_vector_unit #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_WIDTH      = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          quat_w,
  input  logic signed [15:0]          quat_x,
  input  logic signed [15:0]          quat_y,
  input  logic signed [15:0]          quat_z,
  input  logic signed [VEC_WIDTH-1:0] vec_x,
  input  logic signed [VEC_WIDTH-1:0] vec_y,
  input  logic signed [VEC_WIDTH-1:0] vec_z,
  output logic                        done,
  output logic signed [VEC_WIDTH-1:0] rot_x,
  output logic signed [VEC_WIDTH-1:0] rot_y,
  output logic signed [VEC_WIDTH-1:0] rot_z,
  output logic                        clipped
);

  localparam int VW     = VEC_WIDTH;
  localparam int SIDE_W = 3 * VW;
  localparam int LAT    = 1 + qrv_pkg::SQ_LAT + qrv_pkg::DIV_LAT + qrv_pkg::ROT_LAT;

  assign busy = rst;

  // Input register
  logic                 in_v;
  qrv_pkg::quat_t       in_q;
  logic [SIDE_W-1:0]    in_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    in_q <= {quat_z, quat_y, quat_x, quat_w};
    in_s <= {vec_z, vec_y, vec_x};
  end

  // Magnitude
  logic                         sq_v;
  logic [qrv_pkg::ROOT_W-1:0]   sq_root;
  qrv_pkg::quat_t               sq_q;
  logic [SIDE_W-1:0]            sq_s;

  qrv_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_v),
    .in_quat   (in_q),
    .in_side   (in_s),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_quat  (sq_q),
    .out_side  (sq_s)
  );

  // Normalized conjugate
  logic                 dv_v;
  qrv_pkg::conj_t       dv_c;
  qrv_pkg::quat_t       dv_q;
  logic [SIDE_W-1:0]    dv_s;

  qrv_div #(.SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_v),
    .in_root   (sq_root),
    .in_quat   (sq_q),
    .in_side   (sq_s),
    .out_valid (dv_v),
    .out_conj  (dv_c),
    .out_quat  (dv_q),
    .out_side  (dv_s)
  );

  // Rotation
  logic signed [VW-1:0] dv_vec [3];
  logic signed [VW-1:0] rot    [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dv_vec[r] = dv_s[r*VW +: VW];
    end
  end

  qrv_rotate #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_v),
    .in_quat   (dv_q),
    .in_conj   (dv_c),
    .in_vec    (dv_vec),
    .out_valid (done),
    .out_rot   (rot),
    .out_clip  (clipped)
  );

  assign rot_x = rot[0];
  assign rot_y = rot[1];
  assign rot_z = rot[2];

  // A result beat always traces back to an accepted beat
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted input beat");

  // Zero quaternion gives a zero vector, no clipping
  a_zero_quat: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && quat_w == 16'sd0 && quat_x == 16'sd0 &&
                   quat_y == 16'sd0 && quat_z == 16'sd0, LAT))
    |-> (rot_x == '0 && rot_y == '0 && rot_z == '0 && !clipped))
    else $error("zero quaternion did not give a zero vector");

  // Identity quaternion passes the vector through unchanged
  a_identity: assert property (@(posedge clk) disable iff (rst)
    (QUAT_FRAC_BITS < 15 && done &&
     $past(start && !busy && quat_w == 16'(1 << QUAT_FRAC_BITS) && quat_x == 16'sd0 &&
           quat_y == 16'sd0 && quat_z == 16'sd0, LAT))
    |-> (rot_x == $past(vec_x, LAT) && rot_y == $past(vec_y, LAT) &&
         rot_z == $past(vec_z, LAT) && !clipped))
    else $error("identity quaternion changed the vector");

endmodule

FILE: hw/rtl/qrv_sqrt.sv
// Pipelined integer square root of |q|^2 * 2^30, one result bit per stage.
module qrv_sqrt #(
  parameter int SIDE_W = 96
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  qrv_pkg::quat_t              in_quat,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [qrv_pkg::ROOT_W-1:0]  out_root,
  output qrv_pkg::quat_t              out_quat,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int NS = qrv_pkg::ROOT_W;

  logic                         vld  [NS+1];
  logic [qrv_pkg::RAD_W-1:0]    rad  [NS+1];
  logic [qrv_pkg::REM_W-1:0]    rmd  [NS+1];
  logic [qrv_pkg::ROOT_W-1:0]   root [NS+1];
  qrv_pkg::quat_t               quat [NS+1];
  logic [SIDE_W-1:0]            side [NS+1];

  // Sum of squares, exact in 33 bits
  logic signed [31:0] sq [4];
  logic [32:0]        n2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq[i] = $signed(in_quat[i]) * $signed(in_quat[i]);
    end
    n2 = 33'(unsigned'(sq[0])) + 33'(unsigned'(sq[1])) + 33'(unsigned'(sq[2]))
       + 33'(unsigned'(sq[3]));
  end

  // Entry stage: radicand = n2 << 30
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rad[0]  <= qrv_pkg::RAD_W'({n2, {qrv_pkg::C_FRAC{1'b0}}});
    rmd[0]  <= '0;
    root[0] <= '0;
    quat[0] <= in_quat;
    side[0] <= in_side;
  end

  // One root bit per stage, two radicand bits shifted in
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [qrv_pkg::REM_W+1:0] rsh;
    logic [qrv_pkg::REM_W+1:0] trial;
    logic [qrv_pkg::REM_W+1:0] diff;
    logic                      fit;

    always_comb begin
      rsh   = {rmd[k-1], rad[k-1][qrv_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, root[k-1], 2'b01};
      diff  = rsh - trial;
      fit   = (rsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rad[k]  <= {rad[k-1][qrv_pkg::RAD_W-3:0], 2'b00};
      rmd[k]  <= fit ? diff[qrv_pkg::REM_W-1:0] : rsh[qrv_pkg::REM_W-1:0];
      root[k] <= {root[k-1][qrv_pkg::ROOT_W-2:0], fit};
      quat[k] <= quat[k-1];
      side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[NS];
  assign out_root  = root[NS];
  assign out_quat  = quat[NS];
  assign out_side  = side[NS];

endmodule

FILE: hw/rtl/qrv_div.sv
// Four-lane pipelined divider forming the normalized conjugate, one quotient bit per stage.
module qrv_div #(
  parameter int SIDE_W = 96
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [qrv_pkg::ROOT_W-1:0]  in_root,
  input  qrv_pkg::quat_t              in_quat,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output qrv_pkg::conj_t              out_conj,
  output qrv_pkg::quat_t              out_quat,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int NS = qrv_pkg::QUOT_W;
  localparam int RW = qrv_pkg::ROOT_W;
  localparam int QW = qrv_pkg::QUOT_W;

  logic                 vld  [NS+1];
  logic [RW-1:0]        dvs  [NS+1];
  logic                 zro  [NS+1];
  logic [RW-1:0]        rmd  [NS+1][4];
  logic [QW-1:0]        low  [NS+1][4];
  logic [QW-1:0]        quo  [NS+1][4];
  logic                 neg  [NS+1][4];
  qrv_pkg::quat_t       quat [NS+1];
  logic [SIDE_W-1:0]    side [NS+1];

  // Dividend per lane: |q_i| * 2^45 + floor(m/2), sign of (w,-x,-y,-z)
  logic [qrv_pkg::QUAT_W-1:0] mag [4];
  logic [qrv_pkg::NUM_W-1:0]  num [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = in_quat[i][qrv_pkg::QUAT_W-1] ? qrv_pkg::QUAT_W'(-in_quat[i]) : in_quat[i];
      num[i] = {mag[i], 45'd0} + qrv_pkg::NUM_W'(in_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    dvs[0]  <= in_root;
    zro[0]  <= (in_root == '0);
    quat[0] <= in_quat;
    side[0] <= in_side;
    for (int i = 0; i < 4; i++) begin
      rmd[0][i] <= RW'(num[i][qrv_pkg::NUM_W-1:QW]);
      low[0][i] <= num[i][QW-1:0];
      quo[0][i] <= '0;
      neg[0][i] <= in_quat[i][qrv_pkg::QUAT_W-1] ^ (i != 0);
    end
  end

  // Restoring divide step on all four lanes
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [RW:0] rsh  [4];
    logic [RW:0] diff [4];
    logic        fit  [4];

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rsh[i]  = {rmd[k-1][i], low[k-1][i][QW-1]};
        diff[i] = rsh[i] - {1'b0, dvs[k-1]};
        fit[i]  = (rsh[i] >= {1'b0, dvs[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      dvs[k]  <= dvs[k-1];
      zro[k]  <= zro[k-1];
      quat[k] <= quat[k-1];
      side[k] <= side[k-1];
      for (int i = 0; i < 4; i++) begin
        rmd[k][i] <= fit[i] ? diff[i][RW-1:0] : rsh[i][RW-1:0];
        low[k][i] <= {low[k-1][i][QW-2:0], 1'b0};
        quo[k][i] <= {quo[k-1][i][QW-2:0], fit[i]};
        neg[k][i] <= neg[k-1][i];
      end
    end
  end

  // Apply sign; zero quaternion leaves the conjugate at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[NS];
    end
    out_quat <= quat[NS];
    out_side <= side[NS];
    for (int i = 0; i < 4; i++) begin
      if (zro[NS]) begin
        out_conj[i] <= '0;
      end else if (neg[NS][i]) begin
        out_conj[i] <= -qrv_pkg::C_W'({1'b0, quo[NS][i]});
      end else begin
        out_conj[i] <= qrv_pkg::C_W'({1'b0, quo[NS][i]});
      end
    end
  end

endmodule

FILE: hw/rtl/qrv_rotate.sv
// Rotation matrix build, matrix-vector product, rounding and saturation stages.
module qrv_rotate #(
  parameter int VEC_WIDTH      = 32,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  qrv_pkg::quat_t              in_quat,
  input  qrv_pkg::conj_t              in_conj,
  input  logic signed [VEC_WIDTH-1:0] in_vec [3],
  output logic                        out_valid,
  output logic signed [VEC_WIDTH-1:0] out_rot [3],
  output logic                        out_clip
);

  localparam int VW    = VEC_WIDTH;
  localparam int MW    = qrv_pkg::M_W;
  localparam int SP    = qrv_pkg::SPLIT;
  localparam int HW    = MW - SP;
  localparam int ACC_W = VW + 54;
  localparam int SH    = QUAT_FRAC_BITS + qrv_pkg::C_FRAC;
  localparam logic signed [ACC_W-1:0] RND  = {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [ACC_W-1:0] MAXV = ({{(ACC_W-1){1'b0}}, 1'b1} << (VW - 1)) - 1;
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - 1;

  // Stage A: all sixteen products q_i * c_j
  logic                              va;
  logic signed [qrv_pkg::QC_W-1:0]   qc [4][4];
  logic signed [VW-1:0]              vec_a [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        qc[i][j] <= $signed(in_quat[i]) * $signed(in_conj[j]);
      end
    end
    vec_a <= in_vec;
  end

  // Stage B: 3x3 matrix, row = output component, column = input component
  logic signed [MW-1:0] e [4][4];
  logic signed [MW-1:0] mat_next [9];
  logic                 vb;
  logic signed [MW-1:0] mat [9];
  logic signed [VW-1:0] vec_b [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = MW'(qc[i][j]);
      end
    end
    mat_next[0] =  e[0][0] - e[1][1] + e[2][2] + e[3][3];
    mat_next[1] = -e[3][0] - e[2][1] + e[0][3] - e[1][2];
    mat_next[2] =  e[2][0] - e[3][1] - e[1][3] - e[0][2];
    mat_next[3] =  e[3][0] - e[1][2] - e[2][1] - e[0][3];
    mat_next[4] =  e[0][0] - e[2][2] + e[1][1] + e[3][3];
    mat_next[5] = -e[1][0] - e[3][2] + e[0][1] - e[2][3];
    mat_next[6] = -e[2][0] - e[1][3] + e[0][2] - e[3][1];
    mat_next[7] =  e[1][0] - e[2][3] - e[3][2] - e[0][1];
    mat_next[8] =  e[0][0] - e[3][3] + e[2][2] + e[1][1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    mat   <= mat_next;
    vec_b <= vec_a;
  end

  // Stage C: split products, high part signed, low part unsigned
  logic                    vc;
  logic signed [HW+VW-1:0] ph [9];
  logic signed [SP+VW:0]   pl [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    for (int n = 0; n < 9; n++) begin
      ph[n] <= $signed(mat[n][MW-1:SP]) * vec_b[n % 3];
      pl[n] <= $signed({1'b0, mat[n][SP-1:0]}) * vec_b[n % 3];
    end
  end

  // Stage D: recombine each matrix-vector product
  logic                    vd;
  logic signed [ACC_W-1:0] prod [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    for (int n = 0; n < 9; n++) begin
      prod[n] <= (ACC_W'(ph[n]) <<< SP) + ACC_W'(pl[n]);
    end
  end

  // Stage E: row sums plus rounding constant
  logic                    ve;
  logic signed [ACC_W-1:0] acc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
    for (int r = 0; r < 3; r++) begin
      acc[r] <= prod[3*r] + prod[3*r+1] + prod[3*r+2] + RND;
    end
  end

  // Stage F: scale back to vector format and saturate
  logic signed [ACC_W-1:0] scl [3];
  logic                    sat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      scl[r] = acc[r] >>> SH;
      sat[r] = (scl[r] > MAXV) || (scl[r] < MINV);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ve;
    end
    for (int r = 0; r < 3; r++) begin
      if (sat[r]) begin
        out_rot[r] <= scl[r][ACC_W-1] ? MINV[VW-1:0] : MAXV[VW-1:0];
      end else begin
        out_rot[r] <= scl[r][VW-1:0];
      end
    end
    out_clip <= sat[0] | sat[1] | sat[2];
  end

endmodule

FILE: test/tb_quaternion_rotate_vector_unit.sv
// Self-checking testbench for the quaternion vector rotation unit.
module tb_quaternion_rotate_vector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QFB     = 14;
  localparam int VW      = 32;
  localparam int LAT     = 73;
  localparam int N_RAND  = 1925;

  typedef struct {
    logic signed [15:0] q[4];
    logic signed [31:0] v[3];
  } beat_in_t;

  typedef struct {
    logic signed [31:0] r[3];
    logic               clip;
  } beat_out_t;

  // Directed stimulus row; chk marks a typed-in expected result
  typedef struct {
    beat_in_t  stim;
    bit        chk;
    beat_out_t res;
  } row_t;

  logic clk, rst, start, busy, done, clipped;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0] vec_x, vec_y, vec_z, rot_x, rot_y, rot_z;

  beat_out_t rot_fifo[$];
  int        err_cnt;
  int        got_cnt;
  int        clip_cnt;
  int        zero_cnt;
  bit        idle_on;

  quaternion_rotate_vector_unit #(.QUAT_FRAC_BITS(QFB), .VEC_WIDTH(VW)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("quaternion_rotate_vector_unit regression: fail");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Integer square root of a 64-bit value, bit by bit
  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Rotated vector: (q * (0,v)) * normalized conjugate, rounded and saturated
  function automatic beat_out_t rotate(input beat_in_t b);
    beat_out_t o;
    logic signed [63:0]  qi[4], vi[3], cj[4];
    logic signed [63:0]  pq[4][3];
    logic [63:0]         n2, m, mag;
    logic signed [127:0] acc, sh;
    logic signed [127:0] hi_lim, lo_lim;
    int                  pi, ci;
    bit                  sub;
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      qi[i] = b.q[i];
      n2 += qi[i] * qi[i];
      cj[i] = 0;
    end
    for (int i = 0; i < 3; i++) vi[i] = b.v[i];
    if (n2 != 0) begin
      m = root64(n2 << 30);
      for (int i = 0; i < 4; i++) begin
        mag = (qi[i] < 0) ? -qi[i] : qi[i];
        mag = ((mag << 45) + (m >> 1)) / m;
        cj[i] = ((qi[i] < 0) ^ (i != 0)) ? -$signed(mag) : $signed(mag);
      end
    end
    pq[0][0] = -(qi[1]*vi[0]); pq[0][1] = -(qi[2]*vi[1]); pq[0][2] = -(qi[3]*vi[2]);
    pq[1][0] = qi[0]*vi[0];    pq[1][1] = qi[2]*vi[2];    pq[1][2] = -(qi[3]*vi[1]);
    pq[2][0] = qi[0]*vi[1];    pq[2][1] = qi[3]*vi[0];    pq[2][2] = -(qi[1]*vi[2]);
    pq[3][0] = qi[0]*vi[2];    pq[3][1] = qi[1]*vi[1];    pq[3][2] = -(qi[2]*vi[0]);
    hi_lim = (128'sd1 <<< (VW-1)) - 1;
    lo_lim = -(128'sd1 <<< (VW-1));
    o.clip = 1'b0;
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        // Hamilton product term order for output j
        case (k)
          0: begin pi = j + 1; ci = 0; sub = 0; end
          1: begin pi = 0; ci = j + 1; sub = 0; end
          2: begin pi = (j + 1) % 3 + 1; ci = (j + 2) % 3 + 1; sub = 0; end
          default: begin pi = (j + 2) % 3 + 1; ci = (j + 1) % 3 + 1; sub = 1; end
        endcase
        for (int i = 0; i < 3; i++) begin
          if (sub) acc -= 128'(pq[pi][i]) * 128'(cj[ci]);
          else     acc += 128'(pq[pi][i]) * 128'(cj[ci]);
        end
      end
      acc += 128'sd1 <<< (QFB + 29);
      sh = acc >>> (QFB + 30);
      if (sh > hi_lim) begin
        o.r[j] = hi_lim[31:0];
        o.clip = 1'b1;
      end else if (sh < lo_lim) begin
        o.r[j] = lo_lim[31:0];
        o.clip = 1'b1;
      end else begin
        o.r[j] = sh[31:0];
      end
    end
    return o;
  endfunction

  function automatic beat_in_t mk(input int w, x, y, z, input int a, bb, c);
    beat_in_t b;
    b.q[0] = 16'(w); b.q[1] = 16'(x); b.q[2] = 16'(y); b.q[3] = 16'(z);
    b.v[0] = a; b.v[1] = bb; b.v[2] = c;
    return b;
  endfunction

  // Random beat: mostly plausible quaternions, some extremes and zeros
  function automatic beat_in_t rand_beat();
    beat_in_t b;
    int sel;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      case (sel)
        0: b.q[i] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        1: b.q[i] = (i == 0) ? 16'sd0 : $signed(16'($urandom_range(0, 7)) - 16'd3);
        default: b.q[i] = 16'($urandom);
      endcase
    end
    if (sel == 2) for (int i = 0; i < 4; i++) b.q[i] = 16'sd0;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0: b.v[i] = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        1: b.v[i] = $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
        default: b.v[i] = $urandom;
      endcase
    end
    return b;
  endfunction

  // Drive one beat, wait for acceptance, queue the expected rotation
  task automatic send(input beat_in_t b, input bit chk, input beat_out_t want);
    beat_out_t p;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start  <= 1'b1;
    quat_w <= b.q[0]; quat_x <= b.q[1]; quat_y <= b.q[2]; quat_z <= b.q[3];
    vec_x  <= b.v[0]; vec_y  <= b.v[1]; vec_z  <= b.v[2];
    do @(posedge clk); while (busy);
    p = rotate(b);
    if (chk && (p.r[0] !== want.r[0] || p.r[1] !== want.r[1] ||
                p.r[2] !== want.r[2] || p.clip !== want.clip))
      report("table row vs predictor", p.r[0], want.r[0]);
    if (b.q[0] == 0 && b.q[1] == 0 && b.q[2] == 0 && b.q[3] == 0) zero_cnt++;
    rot_fifo.push_back(p);
    @(negedge clk);
  endtask

  // Result checker: done is a one-cycle strobe
  always @(posedge clk) begin
    beat_out_t e;
    if (!rst && done) begin
      got_cnt++;
      if (rot_fifo.size() == 0) begin
        report("unexpected beat", rot_x, 32'd0);
      end else begin
        e = rot_fifo.pop_front();
        if (rot_x !== e.r[0]) report("rot_x", rot_x, e.r[0]);
        if (rot_y !== e.r[1]) report("rot_y", rot_y, e.r[1]);
        if (rot_z !== e.r[2]) report("rot_z", rot_z, e.r[2]);
        if (clipped !== e.clip) report("clipped", 32'(clipped), 32'(e.clip));
        if (clipped) clip_cnt++;
      end
    end
  end

  row_t      dir_tab[$];
  beat_out_t z0;

  initial begin
    int wait_cnt;
    err_cnt = 0; got_cnt = 0; clip_cnt = 0; zero_cnt = 0; idle_on = 1'b1;
    rst = 1'b1; start = 1'b0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    vec_x = 0; vec_y = 0; vec_z = 0;
    z0.r[0] = 0; z0.r[1] = 0; z0.r[2] = 0; z0.clip = 0;

    // Zero quaternion gives zero with no clip; identity passes v through;
    // w = -2.0 doubles the vector, clipping the extremes
    dir_tab.push_back('{mk(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 123), 1, z0});
    dir_tab.push_back('{mk(16384, 0, 0, 0, 1000, -2000, 3000), 1,
                        '{'{1000, -2000, 3000}, 1'b0}});
    dir_tab.push_back('{mk(16384, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0), 1,
                        '{'{32'h7fffffff, 32'h80000000, 0}, 1'b0}});
    dir_tab.push_back('{mk(-32768, 0, 0, 0, 32'h7fffffff, 32'h80000000, -1), 1,
                        '{'{32'h7fffffff, 32'h80000000, -2}, 1'b1}});
    dir_tab.push_back('{mk(32767, 32767, 32767, 32767, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff), 0, z0});
    dir_tab.push_back('{mk(-32768, -32768, -32768, -32768, 32'h80000000, 32'h80000000,
                           32'h80000000), 0, z0});
    dir_tab.push_back('{mk(11585, 0, 0, 11585, 32768, 0, 0), 0, z0});
    dir_tab.push_back('{mk(0, 16384, 0, 0, 32768, 32768, 32768), 0, z0});
    dir_tab.push_back('{mk(0, 0, 16384, 0, -32768, 65536, 7), 0, z0});
    dir_tab.push_back('{mk(0, 0, 0, -16384, 1, -1, 1), 0, z0});
    dir_tab.push_back('{mk(1, 0, 0, 0, 5, 6, 7), 0, z0});
    dir_tab.push_back('{mk(0, 0, 0, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, z0});
    dir_tab.push_back('{mk(-1, -1, -1, -1, 32'h80000000, 32'h7fffffff, 0), 0, z0});
    dir_tab.push_back('{mk(8192, 8192, 8192, 8192, 1, 2, 3), 0, z0});
    dir_tab.push_back('{mk(32767, -32768, 32767, -32768, -1, -1, -1), 0, z0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send(dir_tab[i].stim, dir_tab[i].chk, dir_tab[i].res);

    for (int n = 0; n < N_RAND; n++) begin
      // Drain the pipe once midway
      if (n == N_RAND / 2) begin
        start <= 1'b0;
        while (rot_fifo.size() != 0) @(negedge clk);
      end
      if (n == N_RAND - 300) idle_on = 1'b0;
      send(rand_beat(), 0, z0);
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (rot_fifo.size() != 0 && wait_cnt < 10 * LAT) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (LAT + 10) @(negedge clk);

    $display("Covered %0d beats (%0d zero quaternions, %0d clipped results).",
             got_cnt, zero_cnt, clip_cnt);
    $display("Pending expectations: %0d, mismatches: %0d.", rot_fifo.size(), err_cnt);
    if (err_cnt == 0 && rot_fifo.size() == 0) begin
      $display("quaternion_rotate_vector_unit regression: pass");
    end else begin
      $display("quaternion_rotate_vector_unit regression: fail");
    end
    $finish;
  end

endmodule
